>>> sv/optical_flow_lag_spread_fir_assert.svh
// Assertion helpers used by the back end RTL (ofl_back).
`ifndef OPTICAL_FLOW_LAG_SPREAD_FIR_ASSERT_SVH
`define OPTICAL_FLOW_LAG_SPREAD_FIR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OFL_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OFL_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ofl_pkg.sv
`timescale 1ns / 1ps

package ofl_pkg;

  // Ring geometry
  localparam int HISTORY_LENGTH = 24;
  localparam int RING_PAIRS     = HISTORY_LENGTH / 2;
  localparam int PAIR_IDX_W     = $clog2(RING_PAIRS);

  // Field widths
  localparam int RAW_W      = 8;
  localparam int DISP_W     = RAW_W + 1;
  localparam int MAG_W      = RAW_W;
  localparam int IDLE_W     = 7;
  localparam int LAG_W      = IDLE_W + 1;
  localparam int COEF_W     = 16;
  localparam int OUT_W      = 25;
  localparam int PROD_W     = DISP_W + 1 + COEF_W + 1;
  localparam int ACC_W      = PROD_W + 2;
  localparam int NUM_TAPS   = 6;
  localparam int TAP_W      = $clog2(NUM_TAPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  // Idle tracking
  localparam logic [IDLE_W-1:0] IDLE_RESET    = IDLE_W'(100);
  localparam logic [IDLE_W-1:0] IDLE_CAP      = IDLE_W'(HISTORY_LENGTH / 2);
  localparam logic [IDLE_W-1:0] INVALID_AFTER = IDLE_W'(HISTORY_LENGTH / 4);
  localparam logic [RAW_W-1:0]  THRESH_RESET  = RAW_W'(25);

  // Output saturation limits
  localparam int OUT_MAX_VAL = 9437183;
  localparam int OUT_MIN_VAL = -9437184;

  // Command queue depth
  localparam int CMD_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAP0    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TAP5    = CFG_IDX_W'(6);

  // Reset tap weights, outermost first
  localparam logic [COEF_W-1:0] COEF_RESET [NUM_TAPS] = '{
    16'd8716, 16'd4138, 16'd4858, 16'd5445, 16'd5871, 16'd6089
  };

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Classified burst handed from the front end to the back end
  typedef struct packed {
    logic                     active;
    logic signed [DISP_W-1:0] dx;
    logic signed [DISP_W-1:0] dy;
    logic [LAG_W-1:0]         lag;
    logic                     motion_valid;
    logic                     ground_idle;
  } cmd_t;

  typedef struct packed {
    logic signed [DISP_W-1:0] x;
    logic signed [DISP_W-1:0] y;
  } pair_t;

endpackage

>>> sv/ofl_front.sv
`timescale 1ns / 1ps

module ofl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ofl_pkg::cfg_wr_t              cfg,
  input  logic                          push,
  output logic                          full,
  input  logic signed [ofl_pkg::RAW_W-1:0] raw_dx,
  input  logic signed [ofl_pkg::RAW_W-1:0] raw_dy,
  input  logic [ofl_pkg::RAW_W-1:0]     quality,
  output logic                          cmd_push,
  output ofl_pkg::cmd_t                 cmd,
  input  logic                          cmd_full
);
  import ofl_pkg::*;

  logic [RAW_W-1:0]         thresh_r;
  logic [IDLE_W-1:0]        idle_cnt_r;
  logic [IDLE_W-1:0]        idle_cnt_nxt;
  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DISP_W-1:0] dx_w;
  logic signed [DISP_W-1:0] dy_w;
  logic                     is_idle;
  logic                     accept;

  assign dx_w    = -(DISP_W'(raw_dx));
  assign dy_w    = DISP_W'(raw_dy);
  assign is_idle = (dx_w == '0) && (dy_w == '0) && (quality < thresh_r);
  assign full    = cmd_full;
  assign accept  = push && !cmd_full;
  assign cmd_push = accept;

  // Idle count and valid flag update for the current beat
  always_comb begin
    idle_cnt_nxt = idle_cnt_r;
    valid_nxt    = valid_r;
    if (is_idle) begin
      if (idle_cnt_r < IDLE_CAP) begin
        idle_cnt_nxt = idle_cnt_r + IDLE_W'(1);
        if (idle_cnt_nxt > INVALID_AFTER) begin
          valid_nxt = 1'b0;
        end
      end
    end else begin
      idle_cnt_nxt = '0;
      valid_nxt    = 1'b1;
    end
  end

  // Command for the back end
  always_comb begin
    cmd.active       = !is_idle;
    cmd.dx           = dx_w;
    cmd.dy           = dy_w;
    cmd.lag          = {1'b0, idle_cnt_r} + LAG_W'(1);
    cmd.motion_valid = valid_nxt;
    cmd.ground_idle  = (idle_cnt_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= THRESH_RESET;
      idle_cnt_r <= IDLE_RESET;
      valid_r    <= 1'b0;
    end else begin
      if (cfg.en && (cfg.idx == CFG_QUALITY)) begin
        thresh_r <= cfg.data[RAW_W-1:0];
      end
      if (accept) begin
        idle_cnt_r <= idle_cnt_nxt;
        valid_r    <= valid_nxt;
      end
    end
  end

endmodule

>>> sv/ofl_cmd_fifo.sv
`timescale 1ns / 1ps

module ofl_cmd_fifo #(
  parameter int DEPTH = ofl_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ofl_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output ofl_pkg::cmd_t cmd_out,
  output logic          empty
);
  import ofl_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> sv/ofl_back.sv
`timescale 1ns / 1ps

module ofl_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ofl_pkg::cfg_wr_t                 cfg,
  input  logic                             cmd_empty,
  output logic                             cmd_pop,
  input  ofl_pkg::cmd_t                    cmd,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [ofl_pkg::OUT_W-1:0] smooth_dx,
  output logic signed [ofl_pkg::OUT_W-1:0] smooth_dy,
  output logic                             motion_valid,
  output logic                             ground_idle
);
  import ofl_pkg::*;

  `include "optical_flow_lag_spread_fir_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WRITE,
    S_FIR,
    S_DONE
  } state_t;

  localparam logic [LAG_W-1:0] DIV_LAST = LAG_W'(MAG_W - 1);
  localparam logic [LAG_W-1:0] FIR_LAST = LAG_W'(NUM_TAPS + 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(OUT_MAX_VAL);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(OUT_MIN_VAL);

  // FSM and output registers
  state_t                  state_r;
  logic [LAG_W-1:0]        cnt_r;
  logic [PAIR_IDX_W-1:0]   head_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_dx_r;
  logic signed [OUT_W-1:0] out_dy_r;
  logic                    out_mv_r;
  logic                    out_gi_r;
  logic                    out_load;

  // Command and divider
  cmd_t                    cmd_r;
  logic [MAG_W-1:0]        num_x_r;
  logic [MAG_W-1:0]        num_y_r;
  logic [MAG_W-1:0]        rem_x_r;
  logic [MAG_W-1:0]        rem_y_r;
  logic [MAG_W:0]          trial_x;
  logic [MAG_W:0]          trial_y;
  logic                    ge_x;
  logic                    ge_y;
  logic signed [DISP_W-1:0] qx;
  logic signed [DISP_W-1:0] qy;

  // Ring and filter
  logic [COEF_W-1:0]       coef_r [NUM_TAPS];
  pair_t                   ring_mem [RING_PAIRS];
  logic [RING_PAIRS-1:0]   ring_ok_r;
  logic                    ring_we;
  logic [PAIR_IDX_W-1:0]   head_wrap;
  logic [PAIR_IDX_W:0]     sum_a;
  logic [PAIR_IDX_W:0]     sum_b;
  logic [PAIR_IDX_W-1:0]   addr_a;
  logic [PAIR_IDX_W-1:0]   addr_b;
  logic [TAP_W-1:0]        tap_w;
  logic                    rd_issue;
  pair_t                   rd_a_r;
  pair_t                   rd_b_r;
  logic                    rd_a_ok_r;
  logic                    rd_b_ok_r;
  logic [TAP_W-1:0]        rd_tap_r;
  logic                    rd_v_r;
  logic                    prod_v_r;
  logic signed [DISP_W:0]  pair_sum_x;
  logic signed [DISP_W:0]  pair_sum_y;
  logic signed [PROD_W-1:0] coef_s;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic signed [ACC_W-1:0] acc_x_r;
  logic signed [ACC_W-1:0] acc_y_r;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return c[OUT_W-1:0];
  endfunction

  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || pop);
  assign ring_we  = (state_r == S_WRITE);

  // Restoring divide, one quotient bit per cycle on each lane
  assign trial_x = {rem_x_r, num_x_r[MAG_W-1]};
  assign trial_y = {rem_y_r, num_y_r[MAG_W-1]};
  assign ge_x    = (trial_x >= {1'b0, cmd_r.lag});
  assign ge_y    = (trial_y >= {1'b0, cmd_r.lag});
  assign qx      = cmd_r.dx[DISP_W-1] ? -{1'b0, num_x_r} : {1'b0, num_x_r};
  assign qy      = cmd_r.dy[DISP_W-1] ? -{1'b0, num_y_r} : {1'b0, num_y_r};

  // Ring addressing
  assign head_wrap = (head_r == PAIR_IDX_W'(RING_PAIRS - 1)) ? '0 : head_r + PAIR_IDX_W'(1);
  assign tap_w     = cnt_r[TAP_W-1:0];
  assign rd_issue  = (state_r == S_FIR) && (cnt_r < LAG_W'(NUM_TAPS));
  assign sum_a     = {1'b0, head_r} + {2'b00, tap_w};
  assign sum_b     = {1'b0, head_r} + (PAIR_IDX_W + 1)'(RING_PAIRS - 1) - {2'b00, tap_w};
  assign addr_a    = (sum_a >= (PAIR_IDX_W + 1)'(RING_PAIRS)) ?
                     PAIR_IDX_W'(sum_a - (PAIR_IDX_W + 1)'(RING_PAIRS)) : sum_a[PAIR_IDX_W-1:0];
  assign addr_b    = (sum_b >= (PAIR_IDX_W + 1)'(RING_PAIRS)) ?
                     PAIR_IDX_W'(sum_b - (PAIR_IDX_W + 1)'(RING_PAIRS)) : sum_b[PAIR_IDX_W-1:0];

  // Folded pair sums, never-written slots read as zero
  always_comb begin
    pair_sum_x = (rd_a_ok_r ? (DISP_W + 1)'(rd_a_r.x) : '0) +
                 (rd_b_ok_r ? (DISP_W + 1)'(rd_b_r.x) : '0);
    pair_sum_y = (rd_a_ok_r ? (DISP_W + 1)'(rd_a_r.y) : '0) +
                 (rd_b_ok_r ? (DISP_W + 1)'(rd_b_r.y) : '0);
    coef_s     = PROD_W'($signed({1'b0, coef_r[rd_tap_r]}));
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a beat taken with no replacement this cycle
      if (pop && out_valid_r && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            cnt_r   <= '0;
            state_r <= cmd.active ? S_DIV : S_FIR;
          end
        end
        S_DIV: begin
          if (cnt_r == DIV_LAST) begin
            cnt_r   <= cmd_r.lag;
            state_r <= S_WRITE;
          end else begin
            cnt_r <= cnt_r + LAG_W'(1);
          end
        end
        S_WRITE: begin
          head_r <= head_wrap;
          if (cnt_r == LAG_W'(1)) begin
            cnt_r   <= '0;
            state_r <= S_FIR;
          end else begin
            cnt_r <= cnt_r - LAG_W'(1);
          end
        end
        S_FIR: begin
          if (cnt_r == FIR_LAST) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + LAG_W'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_dx_r    <= sat_out(acc_x_r);
            out_dy_r    <= sat_out(acc_y_r);
            out_mv_r    <= cmd_r.motion_valid;
            out_gi_r    <= cmd_r.ground_idle;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Tap weights and slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r    <= COEF_RESET;
      ring_ok_r <= '0;
      rd_v_r    <= 1'b0;
      prod_v_r  <= 1'b0;
    end else begin
      if (cfg.en && (cfg.idx inside {[CFG_TAP0:CFG_TAP5]})) begin
        coef_r[TAP_W'(cfg.idx - CFG_TAP0)] <= cfg.data;
      end
      if (ring_we) begin
        ring_ok_r[head_r] <= 1'b1;
      end
      rd_v_r   <= rd_issue;
      prod_v_r <= rd_v_r;
    end
  end

  // Command latch and divider datapath
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r   <= cmd;
      num_x_r <= cmd.dx[DISP_W-1] ? MAG_W'(-cmd.dx) : cmd.dx[MAG_W-1:0];
      num_y_r <= cmd.dy[DISP_W-1] ? MAG_W'(-cmd.dy) : cmd.dy[MAG_W-1:0];
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (state_r == S_DIV) begin
      rem_x_r <= ge_x ? MAG_W'(trial_x - {1'b0, cmd_r.lag}) : trial_x[MAG_W-1:0];
      rem_y_r <= ge_y ? MAG_W'(trial_y - {1'b0, cmd_r.lag}) : trial_y[MAG_W-1:0];
      num_x_r <= {num_x_r[MAG_W-2:0], ge_x};
      num_y_r <= {num_y_r[MAG_W-2:0], ge_y};
    end
  end

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[head_r] <= '{x: qx, y: qy};
    end
    rd_a_r    <= ring_mem[addr_a];
    rd_b_r    <= ring_mem[addr_b];
    rd_a_ok_r <= ring_ok_r[addr_a];
    rd_b_ok_r <= ring_ok_r[addr_b];
    rd_tap_r  <= tap_w;
  end

  // Multiply, then accumulate one tap per cycle
  always_ff @(posedge clk) begin
    prod_x_r <= PROD_W'(pair_sum_x) * coef_s;
    prod_y_r <= PROD_W'(pair_sum_y) * coef_s;
    if ((state_r == S_IDLE) || (state_r == S_DIV) || (state_r == S_WRITE)) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (prod_v_r) begin
      acc_x_r <= acc_x_r + ACC_W'(prod_x_r);
      acc_y_r <= acc_y_r + ACC_W'(prod_y_r);
    end
  end

  assign empty        = !out_valid_r;
  assign smooth_dx    = out_dx_r;
  assign smooth_dy    = out_dy_r;
  assign motion_valid = out_mv_r;
  assign ground_idle  = out_gi_r;

  `OFL_ASSERT_NEXT(a_done_holds, clk, rst_n, (state_r == S_DONE) && out_valid_r && !pop, (state_r == S_DONE) && out_valid_r, "finished result dropped while output stalled")
  `OFL_ASSERT_NEXT(a_active_divides, clk, rst_n, cmd_pop && cmd.active, state_r == S_DIV, "active burst skipped the divider")
  `OFL_ASSERT_IMPL(a_pipe_drained, clk, rst_n, state_r == S_DONE, !rd_v_r && !prod_v_r, "filter taps still in flight at result")
  `OFL_ASSERT_NEXT(a_head_moves, clk, rst_n, state_r == S_WRITE, head_r != $past(head_r), "ring head did not advance on write")

endmodule

>>> sv/optical_flow_lag_spread_fir.sv
`timescale 1ns / 1ps
// A motion burst is divided by lag (lag = idle count + 1, normally 1..13, up to 101 on the
// first burst after reset), spread over lag ring slots and filtered; an idle burst only filters.
// The back end takes one beat at a time: its divide, ring write loop (one slot per cycle)
// and folded filter finish before it takes the next beat; up to 4 beats queue in front.
// Reset (rst_n low, synchronous): ring reads as zero, idle count 100, registers to defaults.
module optical_flow_lag_spread_fir #(
  parameter int CMD_DEPTH = ofl_pkg::CMD_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [ofl_pkg::RAW_W-1:0]     in_raw_dx,
  input  logic signed [ofl_pkg::RAW_W-1:0]     in_raw_dy,
  input  logic [ofl_pkg::RAW_W-1:0]            in_surface_quality,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [ofl_pkg::OUT_W-1:0]     out_smooth_dx,
  output logic signed [ofl_pkg::OUT_W-1:0]     out_smooth_dy,
  output logic                                 out_motion_valid,
  output logic                                 out_ground_idle,
  input  logic                                 cfg_we,
  input  logic [ofl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ofl_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ofl_pkg::*;

  cfg_wr_t cfg_w;
  cmd_t    front_cmd;
  cmd_t    queue_cmd;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_pop;
  logic    cmd_empty;

  assign cfg_w.en   = cfg_we;
  assign cfg_w.idx  = cfg_index;
  assign cfg_w.data = cfg_data;

  // Classify bursts and track idle state
  ofl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_w),
    .push     (push),
    .full     (full),
    .raw_dx   (in_raw_dx),
    .raw_dy   (in_raw_dy),
    .quality  (in_surface_quality),
    .cmd_push (cmd_push),
    .cmd      (front_cmd),
    .cmd_full (cmd_full)
  );

  // Decoupling queue
  ofl_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .cmd_in  (front_cmd),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .cmd_out (queue_cmd),
    .empty   (cmd_empty)
  );

  // Divide, ring spread and filter
  ofl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_w),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .cmd          (queue_cmd),
    .empty        (empty),
    .pop          (pop),
    .smooth_dx    (out_smooth_dx),
    .smooth_dy    (out_smooth_dy),
    .motion_valid (out_motion_valid),
    .ground_idle  (out_ground_idle)
  );

endmodule
